/* rtl/pwf_pkg.sv */
// pwf_pkg: shared types, constants and helpers for the lidar point window filter
// used by pwf_cfg_regs and lidar_point_window_filter; no dependencies
`default_nettype none

package pwf_pkg;

	// field widths
	localparam int CoordW = 32;
	localparam int TanW = 27;
	localparam int RangeW = 64;
	localparam int FlagW = 16;
	localparam int ReflW = 8;
	localparam int IdxW = 24;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;
	// tangent bound times rotated x
	localparam int ProdW = TanW + CoordW;
	// Q16.16 numerator scale
	localparam int FracW = 16;

	// register indexes on the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		REG_INCLUDE_MASK  = 3'd0,
		REG_MIN_TAN_HORIZ = 3'd1,
		REG_MAX_TAN_HORIZ = 3'd2,
		REG_MIN_TAN_VERT  = 3'd3,
		REG_MAX_TAN_VERT  = 3'd4,
		REG_MIN_RANGE_SQ  = 3'd5,
		REG_MAX_RANGE_SQ  = 3'd6
	} cfg_reg_t;

	// reset values
	localparam logic [FlagW-1:0] MaskReset = '0;
	localparam logic signed [TanW-1:0] TanResetMax = 27'sd37550000;
	localparam logic signed [TanW-1:0] TanResetMin = -27'sd37550000;
	localparam logic [RangeW-1:0] RangeResetMin = '0;
	localparam logic [RangeW-1:0] RangeResetMax = '1;

	// saturation limits of a coordinate
	localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
	localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};

	typedef struct packed {
		logic [FlagW-1:0]         include_mask;
		logic signed [TanW-1:0]   min_tan_horiz;
		logic signed [TanW-1:0]   max_tan_horiz;
		logic signed [TanW-1:0]   min_tan_vert;
		logic signed [TanW-1:0]   max_tan_vert;
		logic [RangeW-1:0]        min_range_sq;
		logic [RangeW-1:0]        max_range_sq;
	} cfg_t;

	// negate with saturation at the most negative value
	function automatic logic signed [CoordW-1:0] neg_sat(input logic signed [CoordW-1:0] v);
		if (v == CoordMin) begin
			return CoordMax;
		end
		return -v;
	endfunction

	// magnitude of a signed coordinate; the most negative value maps to 2^31
	function automatic logic [CoordW-1:0] mag(input logic signed [CoordW-1:0] v);
		logic signed [CoordW-1:0] n;
		n = -v;
		return v[CoordW-1] ? CoordW'(n) : CoordW'(v);
	endfunction

	// q = num * 2^16 checked against [lo*den, hi*den], sense flipped for negative den
	function automatic logic tan_ok(
		input logic signed [ProdW-1:0] q,
		input logic signed [ProdW-1:0] lo_p,
		input logic signed [ProdW-1:0] hi_p,
		input logic                    den_neg
	);
		if (!den_neg) begin
			return !(q < lo_p) && !(q > hi_p);
		end
		return !(q > lo_p) && !(q < hi_p);
	endfunction

endpackage

`default_nettype wire

/* rtl/pwf_cfg_regs.sv */
// pwf_cfg_regs: configuration register file of the lidar point window filter
// depends on pwf_pkg for the register indexes, reset values and cfg_t
`default_nettype none

module pwf_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [pwf_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [pwf_pkg::CfgDataW-1:0]  cfg_data,
	output pwf_pkg::cfg_t                      cfg
);

	pwf_pkg::cfg_t cfg_q;

	// register writes, indexes beyond the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.include_mask  <= pwf_pkg::MaskReset;
			cfg_q.min_tan_horiz <= pwf_pkg::TanResetMin;
			cfg_q.max_tan_horiz <= pwf_pkg::TanResetMax;
			cfg_q.min_tan_vert  <= pwf_pkg::TanResetMin;
			cfg_q.max_tan_vert  <= pwf_pkg::TanResetMax;
			cfg_q.min_range_sq  <= pwf_pkg::RangeResetMin;
			cfg_q.max_range_sq  <= pwf_pkg::RangeResetMax;
		end else if (cfg_wr_en) begin
			case (pwf_pkg::cfg_reg_t'(cfg_index))
				pwf_pkg::REG_INCLUDE_MASK: begin
					cfg_q.include_mask <= cfg_data[pwf_pkg::FlagW-1:0];
				end
				pwf_pkg::REG_MIN_TAN_HORIZ: begin
					cfg_q.min_tan_horiz <= cfg_data[pwf_pkg::TanW-1:0];
				end
				pwf_pkg::REG_MAX_TAN_HORIZ: begin
					cfg_q.max_tan_horiz <= cfg_data[pwf_pkg::TanW-1:0];
				end
				pwf_pkg::REG_MIN_TAN_VERT: begin
					cfg_q.min_tan_vert <= cfg_data[pwf_pkg::TanW-1:0];
				end
				pwf_pkg::REG_MAX_TAN_VERT: begin
					cfg_q.max_tan_vert <= cfg_data[pwf_pkg::TanW-1:0];
				end
				pwf_pkg::REG_MIN_RANGE_SQ: begin
					cfg_q.min_range_sq <= cfg_data[pwf_pkg::RangeW-1:0];
				end
				pwf_pkg::REG_MAX_RANGE_SQ: begin
					cfg_q.max_range_sq <= cfg_data[pwf_pkg::RangeW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/lidar_point_window_filter.sv */
// lidar_point_window_filter: crop-box filter for a lidar point stream, top level
// depends on pwf_pkg and pwf_cfg_regs
//
// Usage:
//   Points enter on the in_valid/in_ready channel, one transaction per point.
//   Results leave on the out_valid/out_ready channel: kept points with their
//   running index, and every batch_last point, marked kept or not.
//   Three register stages: input (axes rotated), products (tangent bound times
//   rotated x, squared coordinates), result. A result passes through the input,
//   product and result registers in order. The stages advance independently,
//   so one point is accepted every cycle while the receiver does not stall,
//   and bubbles close up; the product stage holds seven multipliers side by side.
//   When the receiver stalls, the result register holds and the stages behind
//   it keep filling until in_ready drops; nothing is lost or repeated.
//   Configuration is written on cfg_wr_en/cfg_index/cfg_data; the user must keep
//   the block idle, which it does not enforce; each write takes effect at once.
//   Reset clears the pipeline, the kept-point counter and restores the default
//   windows (include mask zero, tangents +-573 and range unlimited).
`default_nettype none

module lidar_point_window_filter (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration write port
	input  wire logic                                 cfg_wr_en,
	input  wire logic [pwf_pkg::CfgIdxW-1:0]          cfg_index,
	input  wire logic [pwf_pkg::CfgDataW-1:0]         cfg_data,
	// point input
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [pwf_pkg::CoordW-1:0]    raw_x,
	input  wire logic signed [pwf_pkg::CoordW-1:0]    raw_y,
	input  wire logic signed [pwf_pkg::CoordW-1:0]    raw_z,
	input  wire logic [pwf_pkg::FlagW-1:0]            point_flags,
	input  wire logic [pwf_pkg::ReflW-1:0]            reflectivity,
	input  wire logic                                 frame_start,
	input  wire logic                                 batch_last,
	// result output
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [pwf_pkg::CoordW-1:0]         out_x,
	output logic signed [pwf_pkg::CoordW-1:0]         out_y,
	output logic signed [pwf_pkg::CoordW-1:0]         out_z,
	output logic [pwf_pkg::ReflW-1:0]                 out_reflectivity,
	output logic [pwf_pkg::FlagW-1:0]                 out_flags,
	output logic [pwf_pkg::IdxW-1:0]                  point_index,
	output logic                                      point_kept,
	output logic                                      ends_batch
);

	pwf_pkg::cfg_t cfg;

	pwf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage valids and advance controls
	logic valid_s1;
	logic valid_s2;
	logic out_valid_q;
	logic adv_s1;
	logic adv_s2;
	logic adv_out;

	assign adv_out = !out_valid_q || out_ready;
	assign adv_s2 = !valid_s2 || adv_out;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	// stage 1 payload: rotated point
	logic signed [pwf_pkg::CoordW-1:0] xr_s1;
	logic signed [pwf_pkg::CoordW-1:0] yr_s1;
	logic signed [pwf_pkg::CoordW-1:0] zr_s1;
	logic [pwf_pkg::FlagW-1:0]         flags_s1;
	logic [pwf_pkg::ReflW-1:0]         refl_s1;
	logic                              fstart_s1;
	logic                              last_s1;

	// stage 2 payload: products and squares
	logic signed [pwf_pkg::CoordW-1:0] xr_s2;
	logic signed [pwf_pkg::CoordW-1:0] yr_s2;
	logic signed [pwf_pkg::CoordW-1:0] zr_s2;
	logic [pwf_pkg::FlagW-1:0]         flags_s2;
	logic [pwf_pkg::ReflW-1:0]         refl_s2;
	logic                              fstart_s2;
	logic                              last_s2;
	logic                              pre_ok_s2;
	logic signed [pwf_pkg::ProdW-1:0]  lo_h_s2;
	logic signed [pwf_pkg::ProdW-1:0]  hi_h_s2;
	logic signed [pwf_pkg::ProdW-1:0]  lo_v_s2;
	logic signed [pwf_pkg::ProdW-1:0]  hi_v_s2;
	logic [pwf_pkg::RangeW-1:0]        sqx_s2;
	logic [pwf_pkg::RangeW-1:0]        sqy_s2;
	logic [pwf_pkg::RangeW-1:0]        sqz_s2;

	// result register payload
	logic signed [pwf_pkg::CoordW-1:0] out_x_q;
	logic signed [pwf_pkg::CoordW-1:0] out_y_q;
	logic signed [pwf_pkg::CoordW-1:0] out_z_q;
	logic [pwf_pkg::FlagW-1:0]         out_flags_q;
	logic [pwf_pkg::ReflW-1:0]         out_refl_q;
	logic [pwf_pkg::IdxW-1:0]          point_index_q;
	logic                              point_kept_q;
	logic                              ends_batch_q;

	logic [pwf_pkg::IdxW-1:0] kept_count_q;

	// stage 1 to stage 2: flag and zero checks, multipliers
	logic                              pre_ok_c;
	logic [pwf_pkg::CoordW-1:0]        mag_x;
	logic [pwf_pkg::CoordW-1:0]        mag_y;
	logic [pwf_pkg::CoordW-1:0]        mag_z;
	logic signed [pwf_pkg::ProdW-1:0]  xr_ext;

	always_comb begin
		pre_ok_c = ((~cfg.include_mask & flags_s1) == '0) && (xr_s1 != '0);
		mag_x = pwf_pkg::mag(xr_s1);
		mag_y = pwf_pkg::mag(yr_s1);
		mag_z = pwf_pkg::mag(zr_s1);
		xr_ext = pwf_pkg::ProdW'(xr_s1);
	end

	// stage 2 to result: tangent windows, range window, counter
	logic signed [pwf_pkg::ProdW-1:0] num_h;
	logic signed [pwf_pkg::ProdW-1:0] num_v;
	logic [pwf_pkg::RangeW-1:0]       range_sq;
	logic                             keep_c;
	logic [pwf_pkg::IdxW-1:0]         count_base;

	always_comb begin
		num_h = {{(pwf_pkg::ProdW - pwf_pkg::CoordW - pwf_pkg::FracW){yr_s2[pwf_pkg::CoordW-1]}},
			yr_s2, {pwf_pkg::FracW{1'b0}}};
		num_v = {{(pwf_pkg::ProdW - pwf_pkg::CoordW - pwf_pkg::FracW){zr_s2[pwf_pkg::CoordW-1]}},
			zr_s2, {pwf_pkg::FracW{1'b0}}};
		// at most three times 2^62, fits without carry out
		range_sq = sqx_s2 + sqy_s2 + sqz_s2;
		keep_c = pre_ok_s2
			&& pwf_pkg::tan_ok(num_h, lo_h_s2, hi_h_s2, xr_s2[pwf_pkg::CoordW-1])
			&& pwf_pkg::tan_ok(num_v, lo_v_s2, hi_v_s2, xr_s2[pwf_pkg::CoordW-1])
			&& !(range_sq < cfg.min_range_sq)
			&& !(range_sq > cfg.max_range_sq);
		count_base = fstart_s2 ? '0 : kept_count_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
			kept_count_q <= '0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_out) begin
				out_valid_q <= valid_s2 && (keep_c || last_s2);
			end
			if (valid_s2 && adv_out) begin
				kept_count_q <= keep_c ? count_base + 1'b1 : count_base;
			end
		end
	end

	// stage 1 payload, axes rotated on entry
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			xr_s1 <= raw_y;
			yr_s1 <= pwf_pkg::neg_sat(raw_x);
			zr_s1 <= raw_z;
			flags_s1 <= point_flags;
			refl_s1 <= reflectivity;
			fstart_s1 <= frame_start;
			last_s1 <= batch_last;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			xr_s2 <= xr_s1;
			yr_s2 <= yr_s1;
			zr_s2 <= zr_s1;
			flags_s2 <= flags_s1;
			refl_s2 <= refl_s1;
			fstart_s2 <= fstart_s1;
			last_s2 <= last_s1;
			pre_ok_s2 <= pre_ok_c;
			lo_h_s2 <= pwf_pkg::ProdW'(cfg.min_tan_horiz) * xr_ext;
			hi_h_s2 <= pwf_pkg::ProdW'(cfg.max_tan_horiz) * xr_ext;
			lo_v_s2 <= pwf_pkg::ProdW'(cfg.min_tan_vert) * xr_ext;
			hi_v_s2 <= pwf_pkg::ProdW'(cfg.max_tan_vert) * xr_ext;
			sqx_s2 <= pwf_pkg::RangeW'(mag_x) * pwf_pkg::RangeW'(mag_x);
			sqy_s2 <= pwf_pkg::RangeW'(mag_y) * pwf_pkg::RangeW'(mag_y);
			sqz_s2 <= pwf_pkg::RangeW'(mag_z) * pwf_pkg::RangeW'(mag_z);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv_out && valid_s2) begin
			out_x_q <= xr_s2;
			out_y_q <= yr_s2;
			out_z_q <= zr_s2;
			out_flags_q <= flags_s2;
			out_refl_q <= refl_s2;
			point_index_q <= count_base;
			point_kept_q <= keep_c;
			ends_batch_q <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_z = out_z_q;
	assign out_flags = out_flags_q;
	assign out_reflectivity = out_refl_q;
	assign point_index = point_index_q;
	assign point_kept = point_kept_q;
	assign ends_batch = ends_batch_q;

	// a dropped point only shows up when it closes a batch
	a_drop_only_at_batch_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (point_kept || ends_batch))
		else $error("dropped point delivered without batch end");

	// a kept point never has zero rotated x
	a_kept_nonzero_x: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && point_kept) |-> (out_x != '0))
		else $error("kept point with zero rotated x");

	// a kept point without frame start advances the counter by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && adv_out && keep_c && !fstart_s2)
		|=> (kept_count_q == $past(kept_count_q) + 1'b1))
		else $error("kept counter did not advance");

	// frame start on a dropped point leaves the counter cleared
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && adv_out && fstart_s2 && !keep_c) |=> (kept_count_q == '0))
		else $error("frame start did not clear kept counter");

endmodule

`default_nettype wire

/* verif/lidar_point_window_filter_tb.sv */
// lidar_point_window_filter_tb: self-checking testbench for the lidar point window filter
// depends on pwf_pkg and lidar_point_window_filter; each accepted point is run through an
// in-line copy of the crop-box rules and every result is compared field by field
`default_nettype none

module lidar_point_window_filter_tb;

	localparam int unsigned ResetCycles = 8;
	localparam int unsigned IdleLimit = 1000;
	localparam int unsigned DrainCycles = 6;
	localparam int unsigned RxHoldCycles = 200;
	// index past the last register, must be ignored
	localparam logic [pwf_pkg::CfgIdxW-1:0] RegSpare = 3'd7;
	// widest tangent window that 27 bits can hold
	localparam longint TanLowest = -(64'sd1 <<< 26);
	localparam longint TanHighest = (64'sd1 <<< 26) - 1;
	localparam logic [pwf_pkg::RangeW-1:0] RangeOne = 64'h1_0000_0000;
	localparam int unsigned TxGapPct [6] = '{0, 30, 10, 60, 20, 40};
	localparam int unsigned RxStallPct [6] = '{0, 30, 60, 10, 20, 40};

	typedef struct {
		logic signed [pwf_pkg::CoordW-1:0] x;
		logic signed [pwf_pkg::CoordW-1:0] y;
		logic signed [pwf_pkg::CoordW-1:0] z;
		logic [pwf_pkg::FlagW-1:0]         flags;
		logic [pwf_pkg::ReflW-1:0]         refl;
		logic                              frame_start;
		logic                              batch_last;
	} point_t;

	typedef struct {
		logic signed [pwf_pkg::CoordW-1:0] x;
		logic signed [pwf_pkg::CoordW-1:0] y;
		logic signed [pwf_pkg::CoordW-1:0] z;
		logic [pwf_pkg::ReflW-1:0]         refl;
		logic [pwf_pkg::FlagW-1:0]         flags;
		logic [pwf_pkg::IdxW-1:0]          index;
		logic                              kept;
		logic                              ends_batch;
	} filtered_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_wr_en = 1'b0;
	logic [pwf_pkg::CfgIdxW-1:0]       cfg_index = '0;
	logic [pwf_pkg::CfgDataW-1:0]      cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic signed [pwf_pkg::CoordW-1:0] raw_x = '0;
	logic signed [pwf_pkg::CoordW-1:0] raw_y = '0;
	logic signed [pwf_pkg::CoordW-1:0] raw_z = '0;
	logic [pwf_pkg::FlagW-1:0]         point_flags = '0;
	logic [pwf_pkg::ReflW-1:0]         reflectivity = '0;
	logic                              frame_start = 1'b0;
	logic                              batch_last = 1'b0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic signed [pwf_pkg::CoordW-1:0] out_x;
	logic signed [pwf_pkg::CoordW-1:0] out_y;
	logic signed [pwf_pkg::CoordW-1:0] out_z;
	logic [pwf_pkg::ReflW-1:0]         out_reflectivity;
	logic [pwf_pkg::FlagW-1:0]         out_flags;
	logic [pwf_pkg::IdxW-1:0]          point_index;
	logic                              point_kept;
	logic                              ends_batch;

	// shadow of the window registers and the kept-point counter
	pwf_pkg::cfg_t            window_cfg;
	logic [pwf_pkg::IdxW-1:0] kept_total;
	filtered_t                pending_results[$];

	int unsigned tx_gap_pct = 0;
	int unsigned rx_stall_pct = 0;
	bit          rx_hold_req = 1'b0;
	int unsigned mismatch_count = 0;
	int unsigned idle_cycles = 0;

	lidar_point_window_filter u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.raw_x            (raw_x),
		.raw_y            (raw_y),
		.raw_z            (raw_z),
		.point_flags      (point_flags),
		.reflectivity     (reflectivity),
		.frame_start      (frame_start),
		.batch_last       (batch_last),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_x            (out_x),
		.out_y            (out_y),
		.out_z            (out_z),
		.out_reflectivity (out_reflectivity),
		.out_flags        (out_flags),
		.point_index      (point_index),
		.point_kept       (point_kept),
		.ends_batch       (ends_batch)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		if ($urandom_range(9) == 0) begin
			return $urandom_range(10, 40);
		end
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [63:0] square_mag(input longint v);
		logic [63:0] m;
		m = (v < 0) ? -v : v;
		return m * m;
	endfunction

	// num/den inside [lo, hi] by cross-multiplying; sense flips for negative den
	function automatic bit ratio_in_window(input longint num, input longint den,
			input longint lo, input longint hi);
		longint scaled;
		longint lo_den;
		longint hi_den;
		scaled = num * 65536;
		lo_den = lo * den;
		hi_den = hi * den;
		if (den > 0) begin
			return scaled >= lo_den && scaled <= hi_den;
		end
		return scaled <= lo_den && scaled >= hi_den;
	endfunction

	// rotate, filter and index one point; returns 1 when it yields a result
	function automatic bit predict_filter(input point_t p, output filtered_t r);
		longint xr;
		longint yr;
		longint zr;
		logic [63:0] range_sq;
		bit keep;
		if (p.frame_start) begin
			kept_total = '0;
		end
		xr = longint'(p.y);
		// negating the most negative x saturates
		yr = (p.x == pwf_pkg::CoordMin) ? longint'(pwf_pkg::CoordMax) : -longint'(p.x);
		zr = longint'(p.z);
		keep = ((~window_cfg.include_mask & p.flags) == '0);
		if (keep && xr == 0) begin
			keep = 1'b0;
		end
		if (keep) begin
			range_sq = square_mag(xr) + square_mag(yr) + square_mag(zr);
			keep = ratio_in_window(yr, xr, longint'($signed(window_cfg.min_tan_horiz)),
					longint'($signed(window_cfg.max_tan_horiz)))
				&& ratio_in_window(zr, xr, longint'($signed(window_cfg.min_tan_vert)),
					longint'($signed(window_cfg.max_tan_vert)))
				&& range_sq >= window_cfg.min_range_sq
				&& range_sq <= window_cfg.max_range_sq;
		end
		r.x = pwf_pkg::CoordW'(xr);
		r.y = pwf_pkg::CoordW'(yr);
		r.z = pwf_pkg::CoordW'(zr);
		r.refl = p.refl;
		r.flags = p.flags;
		r.index = kept_total;
		r.kept = keep;
		r.ends_batch = p.batch_last;
		if (keep) begin
			kept_total = kept_total + 1'b1;
		end
		return keep || p.batch_last;
	endfunction

	function automatic point_t make_point(input logic signed [pwf_pkg::CoordW-1:0] x,
			input logic signed [pwf_pkg::CoordW-1:0] y,
			input logic signed [pwf_pkg::CoordW-1:0] z,
			input logic [pwf_pkg::FlagW-1:0] flags, input logic [pwf_pkg::ReflW-1:0] refl,
			input logic fs, input logic bl);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		p.flags = flags;
		p.refl = refl;
		p.frame_start = fs;
		p.batch_last = bl;
		return p;
	endfunction

	function automatic logic signed [pwf_pkg::CoordW-1:0] pick_extreme();
		case ($urandom_range(5))
			0: return pwf_pkg::CoordMin;
			1: return pwf_pkg::CoordMax;
			2: return 0;
			3: return 1;
			4: return -1;
			default: return -65536;
		endcase
	endfunction

	// mostly moderate coordinates, some full range and some at the corners
	function automatic point_t random_point();
		point_t p;
		case ($urandom_range(9))
			0: begin
				p.x = $urandom;
				p.y = $urandom;
				p.z = $urandom;
			end
			1: begin
				p.x = pick_extreme();
				p.y = pick_extreme();
				p.z = pick_extreme();
			end
			default: begin
				p.x = $signed($urandom) >>> $urandom_range(6, 14);
				p.y = $signed($urandom) >>> $urandom_range(6, 14);
				p.z = $signed($urandom) >>> $urandom_range(6, 14);
			end
		endcase
		if ($urandom_range(4) == 0) begin
			p.flags = pwf_pkg::FlagW'($urandom);
		end else begin
			p.flags = pwf_pkg::FlagW'($urandom) & window_cfg.include_mask;
		end
		p.refl = pwf_pkg::ReflW'($urandom);
		p.frame_start = ($urandom_range(29) == 0);
		p.batch_last = ($urandom_range(6) == 0);
		return p;
	endfunction

	// one register write, shadow updated at the same edge
	task automatic write_reg(input logic [pwf_pkg::CfgIdxW-1:0] idx,
			input logic [pwf_pkg::CfgDataW-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			pwf_pkg::REG_INCLUDE_MASK:  window_cfg.include_mask = data[pwf_pkg::FlagW-1:0];
			pwf_pkg::REG_MIN_TAN_HORIZ: window_cfg.min_tan_horiz = data[pwf_pkg::TanW-1:0];
			pwf_pkg::REG_MAX_TAN_HORIZ: window_cfg.max_tan_horiz = data[pwf_pkg::TanW-1:0];
			pwf_pkg::REG_MIN_TAN_VERT:  window_cfg.min_tan_vert = data[pwf_pkg::TanW-1:0];
			pwf_pkg::REG_MAX_TAN_VERT:  window_cfg.max_tan_vert = data[pwf_pkg::TanW-1:0];
			pwf_pkg::REG_MIN_RANGE_SQ:  window_cfg.min_range_sq = data;
			pwf_pkg::REG_MAX_RANGE_SQ:  window_cfg.max_range_sq = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering points and let the pipeline empty out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic program_windows(input logic [pwf_pkg::CfgDataW-1:0] mask,
			input logic [pwf_pkg::CfgDataW-1:0] h_lo, input logic [pwf_pkg::CfgDataW-1:0] h_hi,
			input logic [pwf_pkg::CfgDataW-1:0] v_lo, input logic [pwf_pkg::CfgDataW-1:0] v_hi,
			input logic [pwf_pkg::CfgDataW-1:0] r_lo, input logic [pwf_pkg::CfgDataW-1:0] r_hi);
		wait_drained();
		write_reg(pwf_pkg::REG_INCLUDE_MASK, mask);
		write_reg(pwf_pkg::REG_MIN_TAN_HORIZ, h_lo);
		write_reg(pwf_pkg::REG_MAX_TAN_HORIZ, h_hi);
		write_reg(pwf_pkg::REG_MIN_TAN_VERT, v_lo);
		write_reg(pwf_pkg::REG_MAX_TAN_VERT, v_hi);
		write_reg(pwf_pkg::REG_MIN_RANGE_SQ, r_lo);
		write_reg(pwf_pkg::REG_MAX_RANGE_SQ, r_hi);
	endtask

	// offer one point, hold it until taken, then record what it should yield
	task automatic send_point(input point_t p);
		filtered_t r;
		int unsigned gap;
		if ($urandom_range(99) < tx_gap_pct) begin
			gap = pick_gap();
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_x <= p.x;
		raw_y <= p.y;
		raw_z <= p.z;
		point_flags <= p.flags;
		reflectivity <= p.refl;
		frame_start <= p.frame_start;
		batch_last <= p.batch_last;
		do @(posedge clk); while (!in_ready);
		if (predict_filter(p, r)) begin
			pending_results = {pending_results, r};
		end
	endtask

	// windows as they come out of reset: empty include mask, tangents +-573
	task automatic test_reset_windows();
		tx_gap_pct = 20;
		rx_stall_pct = 20;
		send_point(make_point(-65536, 655360, 0, '0, 8'h11, 1'b1, 1'b0));
		// flag outside the mask, dropped silently
		send_point(make_point(-65536, 655360, 0, 16'h0001, 8'h22, 1'b0, 1'b0));
		// dropped on the last point of a batch: reports the kept total
		send_point(make_point(-65536, 655360, 0, 16'h8000, 8'h33, 1'b0, 1'b1));
		// most negative x saturates on negation
		send_point(make_point(pwf_pkg::CoordMin, 65536, 0, '0, 8'h44, 1'b0, 1'b1));
		// zero rotated x
		send_point(make_point(65536, 0, 65536, '0, 8'h55, 1'b0, 1'b1));
		// most negative rotated x, negative denominator
		send_point(make_point(0, pwf_pkg::CoordMin, 0, '0, 8'hFF, 1'b0, 1'b0));
		// corner coordinates, squared range near the top of 64 bits
		send_point(make_point(pwf_pkg::CoordMax, pwf_pkg::CoordMax, pwf_pkg::CoordMin, '0,
			8'h00, 1'b0, 1'b1));
		send_point(make_point(32'h1000, 32'h2000, 32'h3000, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
	endtask

	// exact window boundaries and crossed windows
	task automatic test_window_edges();
		program_windows(64'hFFFF, TanLowest, TanHighest, TanLowest, TanHighest, '0, '1);
		send_point(make_point(pwf_pkg::CoordMin, 1, 0, 16'hFFFF, 8'h5A, 1'b0, 1'b1));
		send_point(make_point(pwf_pkg::CoordMax, pwf_pkg::CoordMax, 0, 16'hA5A5, 8'hA5,
			1'b0, 1'b0));
		// tangent exactly one horizontally, zero vertically
		program_windows(64'hFFFF, 64'd65536, 64'd65536, '0, '0, '0, '1);
		send_point(make_point(-196608, 196608, 0, '0, 8'h01, 1'b0, 1'b0));
		send_point(make_point(-196609, 196608, 0, '0, 8'h02, 1'b0, 1'b1));
		send_point(make_point(196608, -196608, 0, '0, 8'h03, 1'b0, 1'b0));
		send_point(make_point(196608, -196608, 1, '0, 8'h04, 1'b0, 1'b1));
		// range window a single value wide
		program_windows(64'hFFFF, TanLowest, TanHighest, TanLowest, TanHighest,
			RangeOne, RangeOne);
		send_point(make_point(0, 65536, 0, '0, 8'h05, 1'b0, 1'b0));
		send_point(make_point(0, 65537, 0, '0, 8'h06, 1'b0, 1'b1));
		// minimum above maximum: nothing passes
		program_windows(64'hFFFF, 64'sd1, -64'sd1, TanLowest, TanHighest, '0, '1);
		send_point(make_point(0, 65536, 0, '0, 8'h07, 1'b0, 1'b1));
		program_windows(64'hFFFF, TanLowest, TanHighest, 64'sd1, -64'sd1, '0, '1);
		send_point(make_point(0, 65536, 0, '0, 8'h08, 1'b0, 1'b1));
		program_windows(64'hFFFF, TanLowest, TanHighest, TanLowest, TanHighest,
			RangeOne + 64'd1, RangeOne);
		send_point(make_point(0, 65536, 0, '0, 8'h09, 1'b0, 1'b1));
	endtask

	// a write past the register list changes nothing
	task automatic test_spare_index();
		program_windows(64'hFFFF, TanLowest, TanHighest, TanLowest, TanHighest, '0, '1);
		write_reg(RegSpare, '0);
		send_point(make_point(-65536, 131072, 65536, 16'h00F0, 8'h77, 1'b0, 1'b1));
	endtask

	// receiver holds off while points keep coming, so the input stalls
	task automatic test_backpressure();
		program_windows(64'hFFFF, TanLowest, TanHighest, TanLowest, TanHighest, '0, '1);
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		rx_hold_req = 1'b1;
		repeat (40) send_point(random_point());
	endtask

	// sender waits for the pipeline to empty partway through
	task automatic test_drain_pause();
		tx_gap_pct = 30;
		rx_stall_pct = 30;
		repeat (15) send_point(random_point());
		wait_drained();
		repeat (15) send_point(random_point());
	endtask

	// phases of random points, each with its own windows and pacing
	task automatic test_random_windows(input int unsigned phases, input int unsigned per_phase);
		logic [pwf_pkg::CfgDataW-1:0] r_lo;
		for (int unsigned ph = 0; ph < phases; ph++) begin
			case (ph % 3)
				0: program_windows(64'($urandom), 64'(pwf_pkg::TanResetMin),
					64'(pwf_pkg::TanResetMax), 64'(pwf_pkg::TanResetMin),
					64'(pwf_pkg::TanResetMax), pwf_pkg::RangeResetMin,
					pwf_pkg::RangeResetMax);
				1: begin
					r_lo = 64'($urandom) << $urandom_range(0, 12);
					program_windows(64'($urandom | 32'h00FF),
						-longint'($urandom_range(0, 262144)),
						longint'($urandom_range(0, 262144)),
						-longint'($urandom_range(0, 262144)),
						longint'($urandom_range(0, 262144)),
						r_lo, {$urandom, $urandom} >> $urandom_range(10, 18));
				end
				default: program_windows({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom});
			endcase
			tx_gap_pct = TxGapPct[ph % 6];
			rx_stall_pct = RxStallPct[ph % 6];
			repeat (per_phase) send_point(random_point());
		end
	endtask

	// receiver pacing: random stalls plus one long hold-off on request
	initial begin : pace_receiver
		int unsigned stall;
		wait (arst_n);
		forever begin
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				repeat (RxHoldCycles) @(posedge clk);
				rx_hold_req = 1'b0;
			end else if ($urandom_range(99) < rx_stall_pct) begin
				stall = pick_gap();
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// compare each output transaction with the oldest expected result
	always @(posedge clk) begin : check_results
		filtered_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual x %0h index %0h",
					$time, out_x, point_index);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("out_x", 64'(want.x), 64'(out_x));
				check_field("out_y", 64'(want.y), 64'(out_y));
				check_field("out_z", 64'(want.z), 64'(out_z));
				check_field("out_reflectivity", 64'(want.refl), 64'(out_reflectivity));
				check_field("out_flags", 64'(want.flags), 64'(out_flags));
				check_field("point_index", 64'(want.index), 64'(point_index));
				check_field("point_kept", 64'(want.kept), 64'(point_kept));
				check_field("ends_batch", 64'(want.ends_batch), 64'(ends_batch));
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		window_cfg.include_mask = pwf_pkg::MaskReset;
		window_cfg.min_tan_horiz = pwf_pkg::TanResetMin;
		window_cfg.max_tan_horiz = pwf_pkg::TanResetMax;
		window_cfg.min_tan_vert = pwf_pkg::TanResetMin;
		window_cfg.max_tan_vert = pwf_pkg::TanResetMax;
		window_cfg.min_range_sq = pwf_pkg::RangeResetMin;
		window_cfg.max_range_sq = pwf_pkg::RangeResetMax;
		kept_total = '0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_windows();
		test_window_edges();
		test_spare_index();
		test_backpressure();
		test_drain_pause();
		test_random_windows(6, 210);
		wait_drained();
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
